// File: src/mpir_pkg.sv
// -----------------------------------------------------------------------------
// mpir_pkg
// Types, operation codes and the group enable table of the masked priority
// interrupt register.
// -----------------------------------------------------------------------------
package mpir_pkg;

   localparam int unsigned SOURCE_COUNT = 32;
   localparam int unsigned GROUP_COUNT  = 10;

   typedef enum logic [2:0] {
      OP_SET      = 3'd0,
      OP_CLEAR    = 3'd1,
      OP_CLR_ALL  = 3'd2,
      OP_PUT_NCH  = 3'd3,
      OP_READ     = 3'd4,
      OP_LOAD_MSK = 3'd5,
      OP_SERVE    = 3'd6
   } op_type;

   localparam logic [SOURCE_COUNT-1:0] NMI_BIT   = 32'h8000_0000;
   localparam logic [SOURCE_COUNT-1:0] CHAN_BITS = 32'h000F_FFF0;

   // group g is mask bit 9-g
   localparam logic [SOURCE_COUNT-1:0] GROUP_ENABLE [GROUP_COUNT] = '{
      32'h4000_0000, 32'h2000_0000, 32'h1000_0000, 32'h0800_0000,
      32'h07F0_0000, 32'h000C_0000, 32'h0003_0000, 32'h0000_FC00,
      32'h0000_03F0, 32'h0000_000F
   };

   typedef struct packed {
      logic [2:0]  operation;
      logic [4:0]  source_number;
      logic [15:0] nonchannel_value;
      logic [9:0]  group_mask;
   } req_type;

   typedef struct packed {
      logic        request;
      logic [15:0] nonchannel_word;
      logic [15:0] channel_word;
      logic        served_valid;
      logic [4:0]  served_number;
      logic        served_is_channel;
   } rsp_type;

   // expand the group mask into the 32-bit enable word
   function automatic logic [SOURCE_COUNT-1:0] enable_word(
      input logic [GROUP_COUNT-1:0] mask
   );
      logic [SOURCE_COUNT-1:0] e;
      e = NMI_BIT;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         if (mask[GROUP_COUNT-1-g]) begin
            e = e | GROUP_ENABLE[g];
         end
      end
      return e;
   endfunction

endpackage

// File: src/mpir_if.sv
// -----------------------------------------------------------------------------
// mpir_if
// Valid/ready channels of the masked priority interrupt register: one for
// request items, one for result items.
// -----------------------------------------------------------------------------
interface mpir_req_if;
   logic              valid;
   logic              ready;
   mpir_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mpir_rsp_if;
   logic              valid;
   logic              ready;
   mpir_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: src/masked_priority_interrupt_register.sv
// -----------------------------------------------------------------------------
// masked_priority_interrupt_register
// 32-source pending register with group mask, priority serve and packed
// status words on every result item.
// -----------------------------------------------------------------------------
// Pipeline: an accepted item waits in the input register; the state update and
// the result register take it once that register is empty or being taken.
// Throughput: one item per cycle while the result side takes results; bounded by
// the update of the pending word, which goes through a 32-bit priority encoder
// on serve.
// Reset: pending word and group mask cleared (only the non-maskable source
// enabled), both pipeline stages emptied.
module masked_priority_interrupt_register (
   input  logic        clock,
   input  logic        reset,
   mpir_req_if.sink    req_ch,
   mpir_rsp_if.source  rsp_ch
);

   logic                req_valid_ff;
   mpir_pkg::req_type   req_data_ff;
   logic                rsp_valid_ff;
   mpir_pkg::rsp_type   rsp_data_ff;
   mpir_pkg::rsp_type   rsp_data_in;

   logic [31:0]         pending_ff;
   logic [31:0]         pending_in;
   logic [9:0]          mask_ff;
   logic [9:0]          mask_in;

   logic                advance;
   logic [31:0]         live;
   logic                serve_hit;
   logic [4:0]          serve_num;
   logic [31:0]         src_bit;
   logic [31:0]         enable_in;

   // lowest source number = highest bit; byte-wise encode then byte select
   function automatic logic [4:0] first_source(input logic [31:0] word);
      logic [2:0] pos [4];
      logic [3:0] hit;
      logic [4:0] n;
      n = '0;
      for (int b = 0; b < 4; b++) begin
         pos[b] = '0;
         hit[b] = 1'b0;
         for (int k = 7; k >= 0; k--) begin
            if (word[31 - 8*b - k]) begin
               pos[b] = 3'(k);
               hit[b] = 1'b1;
            end
         end
      end
      for (int b = 3; b >= 0; b--) begin
         if (hit[b]) begin
            n = {2'(b), pos[b]};
         end
      end
      return n;
   endfunction

   assign advance       = req_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !req_valid_ff || advance;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.data   = rsp_data_ff;

   assign live      = pending_ff & mpir_pkg::enable_word(mask_ff);
   assign serve_hit = (live != '0);
   assign serve_num = first_source(live);
   assign src_bit   = mpir_pkg::NMI_BIT >> req_data_ff.source_number;

   always_comb begin
      pending_in = pending_ff;
      mask_in    = mask_ff;
      rsp_data_in.served_valid      = 1'b0;
      rsp_data_in.served_number     = '0;
      rsp_data_in.served_is_channel = 1'b0;
      unique case (mpir_pkg::op_type'(req_data_ff.operation))
         mpir_pkg::OP_SET: begin
            pending_in = pending_ff | src_bit;
         end
         mpir_pkg::OP_CLEAR: begin
            pending_in = pending_ff & ~src_bit;
         end
         mpir_pkg::OP_CLR_ALL: begin
            pending_in = '0;
         end
         mpir_pkg::OP_PUT_NCH: begin
            pending_in = (pending_ff & mpir_pkg::CHAN_BITS)
                       | {req_data_ff.nonchannel_value[15:4], 16'h0000,
                          req_data_ff.nonchannel_value[3:0]};
         end
         mpir_pkg::OP_LOAD_MSK: begin
            mask_in = req_data_ff.group_mask;
         end
         mpir_pkg::OP_SERVE: begin
            if (serve_hit) begin
               pending_in = pending_ff & ~(mpir_pkg::NMI_BIT >> serve_num);
               rsp_data_in.served_valid      = 1'b1;
               rsp_data_in.served_number     = serve_num;
               rsp_data_in.served_is_channel = (serve_num >= 5'd12) &&
                                               (serve_num <= 5'd27);
            end
         end
         default: begin
            // read and the unused code leave the state alone
         end
      endcase
      enable_in = mpir_pkg::enable_word(mask_in);
      rsp_data_in.request         = ((pending_in & enable_in) != '0);
      rsp_data_in.nonchannel_word = {pending_in[31:20], pending_in[3:0]};
      rsp_data_in.channel_word    = pending_in[19:4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= '0;
         mask_ff      <= '0;
      end else begin
         if (req_ch.ready) begin
            req_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            pending_ff   <= pending_in;
            mask_ff      <= mask_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         req_data_ff <= req_ch.data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // only a serve reports a served source
   a_serve_only: assert property (@(posedge clock) disable iff (reset)
      advance && (req_data_ff.operation != mpir_pkg::OP_SERVE)
      |=> !rsp_data_ff.served_valid)
      else $error("served source reported for a non-serve item");

   // the encoder picks a live source
   a_serve_live: assert property (@(posedge clock) disable iff (reset)
      serve_hit |-> live[5'd31 - serve_num])
      else $error("priority encoder picked a source that is not live");

   // the served source is cleared
   a_serve_clear: assert property (@(posedge clock) disable iff (reset)
      advance && (req_data_ff.operation == mpir_pkg::OP_SERVE) && serve_hit
      |=> !pending_ff[5'd31 - $past(serve_num)])
      else $error("served source still pending");

   // a held result matches the state it was taken from
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.channel_word == pending_ff[19:4]) &&
         (rsp_data_ff.request ==
          ((pending_ff & mpir_pkg::enable_word(mask_ff)) != '0)))
      else $error("result item out of step with pending state");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb
// Checks the masked priority interrupt register item by item. A directed table
// covers reset state, empty and masked serves, edge sources, the full and empty
// group masks and the spare operation code. About 1900 random items follow,
// weighted towards set and serve. Each result item is compared with a shadow
// model of the pending word and group mask, or with a directed row's status.
// -----------------------------------------------------------------------------
module tb;

   localparam logic [2:0] OP_SPARE    = 3'd7;
   localparam int         RANDOM_ITEMS = 1900;
   localparam int         CYCLE_LIMIT  = 600000;
   localparam int         DRAIN_CYCLES = 8;

   // group g (mask bit 9-g) enables these pending bits
   localparam logic [31:0] GROUP_SPAN [10] = '{
      32'h4000_0000, 32'h2000_0000, 32'h1000_0000, 32'h0800_0000,
      32'h07F0_0000, 32'h000C_0000, 32'h0003_0000, 32'h0000_FC00,
      32'h0000_03F0, 32'h0000_000F
   };

   typedef struct packed {
      logic [2:0]        operation;
      logic [4:0]        source_number;
      logic [15:0]       nonchannel_value;
      logic [9:0]        group_mask;
      logic              typed;
      mpir_pkg::rsp_type status;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   mpir_req_if req_if ();
   mpir_rsp_if rsp_if ();

   masked_priority_interrupt_register u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [31:0]       pend_word;
   logic [9:0]        mask_shadow;
   mpir_pkg::rsp_type expected_status [$];
   logic              typed_pending;
   mpir_pkg::rsp_type typed_status;
   logic              quiet;
   int                fail_count;
   int                cycle_count;

   function automatic logic [31:0] group_enables(input logic [9:0] gm);
      logic [31:0] e;
      e = mpir_pkg::NMI_BIT;
      for (int g = 0; g < 10; g++) begin
         if (gm[9-g]) begin
            e = e | GROUP_SPAN[g];
         end
      end
      return e;
   endfunction

   // applies one item to the shadow state and returns its result item
   function automatic mpir_pkg::rsp_type apply_interrupt_op(input mpir_pkg::req_type item);
      mpir_pkg::rsp_type r;
      logic [31:0]       live;
      logic              found;
      int                pick;
      r     = '0;
      found = 1'b0;
      pick  = 0;
      case (item.operation)
         mpir_pkg::OP_SET: begin
            pend_word = pend_word | (mpir_pkg::NMI_BIT >> item.source_number);
         end
         mpir_pkg::OP_CLEAR: begin
            pend_word = pend_word & ~(mpir_pkg::NMI_BIT >> item.source_number);
         end
         mpir_pkg::OP_CLR_ALL: begin
            pend_word = '0;
         end
         mpir_pkg::OP_PUT_NCH: begin
            pend_word = (pend_word & mpir_pkg::CHAN_BITS)
                      | {item.nonchannel_value[15:4], 16'h0000,
                         item.nonchannel_value[3:0]};
         end
         mpir_pkg::OP_LOAD_MSK: begin
            mask_shadow = item.group_mask;
         end
         mpir_pkg::OP_SERVE: begin
            live = pend_word & group_enables(mask_shadow);
            for (int n = 0; n < 32; n++) begin
               if (!found && live[31-n]) begin
                  found = 1'b1;
                  pick  = n;
               end
            end
            if (found) begin
               pend_word           = pend_word & ~(mpir_pkg::NMI_BIT >> pick);
               r.served_valid      = 1'b1;
               r.served_number     = pick[4:0];
               r.served_is_channel = (pick >= 12 && pick <= 27);
            end
         end
         default: ;
      endcase
      r.request         = |(pend_word & group_enables(mask_shadow));
      r.nonchannel_word = {pend_word[31:20], pend_word[3:0]};
      r.channel_word    = pend_word[19:4];
      return r;
   endfunction

   function automatic mpir_pkg::rsp_type status(input logic rq,
                                                input logic [15:0] ncw,
                                                input logic [15:0] cw,
                                                input logic sv,
                                                input logic [4:0] sn,
                                                input logic sc);
      mpir_pkg::rsp_type r;
      r.request           = rq;
      r.nonchannel_word   = ncw;
      r.channel_word      = cw;
      r.served_valid      = sv;
      r.served_number     = sn;
      r.served_is_channel = sc;
      return r;
   endfunction

   function automatic dir_row_type row(input logic [2:0] op, input logic [4:0] src,
                                       input logic [15:0] ncv, input logic [9:0] gm,
                                       input logic typed,
                                       input mpir_pkg::rsp_type st);
      dir_row_type d;
      d.operation        = op;
      d.source_number    = src;
      d.nonchannel_value = ncv;
      d.group_mask       = gm;
      d.typed            = typed;
      d.status           = st;
      return d;
   endfunction

   // result check first, then the item accepted at this edge
   always @(posedge clock) begin
      mpir_pkg::rsp_type want;
      mpir_pkg::rsp_type got;
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
      if (rsp_if.valid === 1'b1 && rsp_if.ready) begin
         got = rsp_if.data;
         if (expected_status.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("unexpected result item %h", got);
            end
         end else begin
            want = expected_status.pop_front();
            if (got.request !== want.request
                || got.nonchannel_word !== want.nonchannel_word
                || got.channel_word !== want.channel_word
                || got.served_valid !== want.served_valid
                || got.served_number !== want.served_number
                || got.served_is_channel !== want.served_is_channel) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch: req %b/%b nch %h/%h ch %h/%h sv %b/%b sn %0d/%0d sc %b/%b",
                           want.request, got.request,
                           want.nonchannel_word, got.nonchannel_word,
                           want.channel_word, got.channel_word,
                           want.served_valid, got.served_valid,
                           want.served_number, got.served_number,
                           want.served_is_channel, got.served_is_channel);
               end
            end
         end
      end
      if (req_if.valid && req_if.ready === 1'b1) begin
         want = apply_interrupt_op(req_if.data);
         expected_status.push_back(typed_pending ? typed_status : want);
      end
   end

   task automatic offer(input mpir_pkg::req_type item, input logic typed,
                        input mpir_pkg::rsp_type st);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.data   <= item;
      typed_pending <= typed;
      typed_status  <= st;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   // result side stalls in bursts
   initial begin
      rsp_if.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (!quiet && $urandom_range(0, 11) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(negedge clock);
      end
   end

   initial begin
      dir_row_type       dir_table [$];
      mpir_pkg::req_type item;
      mpir_pkg::rsp_type none;
      int                p;
      int                k;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.data   = '0;
      typed_pending = 1'b0;
      typed_status  = '0;
      quiet         = 1'b0;
      fail_count    = 0;
      cycle_count   = 0;
      pend_word     = '0;
      mask_shadow   = '0;
      none          = '0;

      dir_table.push_back(row(mpir_pkg::OP_READ,     5'd0,  16'h0000, 10'h000, 1'b1,
                              status(1'b0, 16'h0000, 16'h0000, 1'b0, 5'd0, 1'b0)));
      // serve on an empty register
      dir_table.push_back(row(mpir_pkg::OP_SERVE,    5'd0,  16'h0000, 10'h000, 1'b1,
                              status(1'b0, 16'h0000, 16'h0000, 1'b0, 5'd0, 1'b0)));
      dir_table.push_back(row(mpir_pkg::OP_SET,      5'd0,  16'h0000, 10'h000, 1'b1,
                              status(1'b1, 16'h8000, 16'h0000, 1'b0, 5'd0, 1'b0)));
      dir_table.push_back(row(mpir_pkg::OP_SERVE,    5'd0,  16'h0000, 10'h000, 1'b1,
                              status(1'b0, 16'h0000, 16'h0000, 1'b1, 5'd0, 1'b0)));
      dir_table.push_back(row(mpir_pkg::OP_SET,      5'd31, 16'h0000, 10'h000, 1'b1,
                              status(1'b0, 16'h0001, 16'h0000, 1'b0, 5'd0, 1'b0)));
      // pending but masked: serve finds nothing, state kept
      dir_table.push_back(row(mpir_pkg::OP_SERVE,    5'd0,  16'hFFFF, 10'h3FF, 1'b1,
                              status(1'b0, 16'h0001, 16'h0000, 1'b0, 5'd0, 1'b0)));
      dir_table.push_back(row(mpir_pkg::OP_CLEAR,    5'd31, 16'h0000, 10'h000, 1'b1,
                              status(1'b0, 16'h0000, 16'h0000, 1'b0, 5'd0, 1'b0)));
      dir_table.push_back(row(mpir_pkg::OP_PUT_NCH,  5'd31, 16'hFFFF, 10'h000, 1'b1,
                              status(1'b1, 16'hFFFF, 16'h0000, 1'b0, 5'd0, 1'b0)));
      dir_table.push_back(row(mpir_pkg::OP_LOAD_MSK, 5'd0,  16'h0000, 10'h3FF, 1'b0, none));
      dir_table.push_back(row(mpir_pkg::OP_SERVE,    5'd0,  16'h0000, 10'h000, 1'b0, none));
      dir_table.push_back(row(mpir_pkg::OP_SERVE,    5'd0,  16'h0000, 10'h000, 1'b0, none));
      dir_table.push_back(row(mpir_pkg::OP_CLR_ALL,  5'd0,  16'h0000, 10'h000, 1'b1,
                              status(1'b0, 16'h0000, 16'h0000, 1'b0, 5'd0, 1'b0)));
      // channel range edges
      dir_table.push_back(row(mpir_pkg::OP_SET,      5'd27, 16'h0000, 10'h000, 1'b0, none));
      dir_table.push_back(row(mpir_pkg::OP_SET,      5'd12, 16'h0000, 10'h000, 1'b0, none));
      dir_table.push_back(row(mpir_pkg::OP_SET,      5'd11, 16'h0000, 10'h000, 1'b0, none));
      dir_table.push_back(row(mpir_pkg::OP_SET,      5'd28, 16'h0000, 10'h000, 1'b0, none));
      dir_table.push_back(row(OP_SPARE,              5'd31, 16'hFFFF, 10'h3FF, 1'b0, none));
      dir_table.push_back(row(mpir_pkg::OP_SERVE,    5'd0,  16'h0000, 10'h000, 1'b0, none));
      dir_table.push_back(row(mpir_pkg::OP_SERVE,    5'd0,  16'h0000, 10'h000, 1'b0, none));
      dir_table.push_back(row(mpir_pkg::OP_LOAD_MSK, 5'd0,  16'h0000, 10'h000, 1'b0, none));
      dir_table.push_back(row(mpir_pkg::OP_SERVE,    5'd0,  16'h0000, 10'h000, 1'b0, none));
      dir_table.push_back(row(mpir_pkg::OP_LOAD_MSK, 5'd0,  16'h0000, 10'h001, 1'b0, none));
      dir_table.push_back(row(mpir_pkg::OP_SERVE,    5'd0,  16'h0000, 10'h000, 1'b0, none));
      dir_table.push_back(row(mpir_pkg::OP_PUT_NCH,  5'd0,  16'h0000, 10'h200, 1'b0, none));
      dir_table.push_back(row(mpir_pkg::OP_READ,     5'd0,  16'h0000, 10'h000, 1'b0, none));

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         item.operation        = dir_table[i].operation;
         item.source_number    = dir_table[i].source_number;
         item.nonchannel_value = dir_table[i].nonchannel_value;
         item.group_mask       = dir_table[i].group_mask;
         offer(item, dir_table[i].typed, dir_table[i].status);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet = (i >= 1100 && i < 1250) || i >= RANDOM_ITEMS - 200;
         if (i == 900) begin
            // let the block drain completely once
            @(negedge clock);
            req_if.valid <= 1'b0;
            while (expected_status.size() != 0) @(posedge clock);
         end
         p = $urandom_range(0, 99);
         if (p < 28)      item.operation = mpir_pkg::OP_SET;
         else if (p < 36) item.operation = mpir_pkg::OP_CLEAR;
         else if (p < 39) item.operation = mpir_pkg::OP_CLR_ALL;
         else if (p < 47) item.operation = mpir_pkg::OP_PUT_NCH;
         else if (p < 53) item.operation = mpir_pkg::OP_READ;
         else if (p < 63) item.operation = mpir_pkg::OP_LOAD_MSK;
         else if (p < 97) item.operation = mpir_pkg::OP_SERVE;
         else             item.operation = OP_SPARE;
         item.source_number    = $urandom_range(0, 31);
         item.nonchannel_value = $urandom_range(0, 65535);
         k = $urandom_range(0, 9);
         if (k == 0)      item.group_mask = 10'h000;
         else if (k == 1) item.group_mask = 10'h3FF;
         else             item.group_mask = $urandom_range(0, 1023);
         offer(item, 1'b0, none);
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
